FILE: rtl/core/cpts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpts_pkg
// Shared types and constants of the conveyor photo trigger sequencer.
// ----------------------------------------------------------------------------
package cpts_pkg;

  // Qualifier thresholds (tick counts)
  localparam logic [2:0] QUAL_SET       = 3'd3;
  localparam logic [2:0] QUAL_CLEAR     = 3'd6;
  localparam logic [2:0] LEVEL_UP_SET   = 3'd2;
  localparam logic [2:0] LEVEL_UP_CLEAR = 3'd4;
  localparam logic [2:0] LEVEL_DN_SET   = 3'd3;
  localparam logic [2:0] LEVEL_DN_CLEAR = 3'd6;

  // Photo sequence fixed points
  localparam logic [8:0] STROBE_FORCE_END = 9'd60;
  localparam logic [8:0] TRIGGER_RELEASE  = 9'd61;

  // Configuration register indexes
  localparam logic [7:0] REG_BASE_PERIOD  = 8'd0;
  localparam logic [7:0] REG_PULSE_WIDTH  = 8'd1;
  localparam logic [7:0] REG_TRIGGER_LOW  = 8'd2;
  localparam logic [7:0] REG_STROBE_TICKS = 8'd3;

  // Configuration reset values
  localparam logic [15:0] RST_BASE_PERIOD  = 16'd1000;
  localparam logic [15:0] RST_PULSE_WIDTH  = 16'd7;
  localparam logic [7:0]  RST_TRIGGER_LOW  = 8'd50;
  localparam logic [7:0]  RST_STROBE_TICKS = 8'd100;

  // State of one rise/fall qualifier
  typedef struct packed {
    logic [2:0] up;
    logic [2:0] dn;
    logic       hi;
    logic       rise;
    logic       fall;
  } qual_st_t;

endpackage

FILE: rtl/core/cpts_qual.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpts_qual
// Rise/fall qualifier for barrier and belt drive: set at 3 ticks, clear at 6.
// ----------------------------------------------------------------------------
module cpts_qual (
  input  logic               x,
  input  cpts_pkg::qual_st_t st,
  output cpts_pkg::qual_st_t st_nxt
);

  always_comb begin
    st_nxt = st;
    if (x && !st_nxt.hi) begin
      st_nxt.up = st_nxt.up + 3'd1;
    end
    if (x && st_nxt.up >= cpts_pkg::QUAL_SET) begin
      st_nxt.rise = 1'b1;
    end
    if (st_nxt.rise && st_nxt.up >= cpts_pkg::QUAL_CLEAR) begin
      st_nxt.rise = 1'b0;
      st_nxt.up   = 3'd0;
      st_nxt.hi   = 1'b1;
    end
    if (!x && st_nxt.hi) begin
      st_nxt.dn = st_nxt.dn + 3'd1;
    end
    if (!x && st_nxt.dn >= cpts_pkg::QUAL_SET) begin
      st_nxt.fall = 1'b1;
    end
    if (st_nxt.fall && st_nxt.dn >= cpts_pkg::QUAL_CLEAR) begin
      st_nxt.fall = 1'b0;
      st_nxt.dn   = 3'd0;
      st_nxt.hi   = 1'b0;
    end
  end

endmodule

FILE: rtl/core/cpts_level_qual.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpts_level_qual
// Level sensor qualifier: rise counter runs on once started, wraps to idle.
// ----------------------------------------------------------------------------
module cpts_level_qual (
  input  logic               x,
  input  cpts_pkg::qual_st_t st,
  output cpts_pkg::qual_st_t st_nxt
);

  always_comb begin
    st_nxt = st;
    if ((x && !st_nxt.hi) || st_nxt.up != 3'd0) begin
      st_nxt.up = st_nxt.up + 3'd1;
    end
    if (x && st_nxt.up >= cpts_pkg::LEVEL_UP_SET && st_nxt.up < cpts_pkg::LEVEL_UP_CLEAR) begin
      st_nxt.rise = 1'b1;
    end
    if (st_nxt.rise && st_nxt.up >= cpts_pkg::LEVEL_UP_CLEAR) begin
      st_nxt.rise = 1'b0;
      st_nxt.up   = 3'd0;
      st_nxt.hi   = 1'b1;
    end
    if (!x && st_nxt.hi) begin
      st_nxt.dn = st_nxt.dn + 3'd1;
    end
    if (!x && st_nxt.dn >= cpts_pkg::LEVEL_DN_SET && st_nxt.dn < cpts_pkg::LEVEL_DN_CLEAR) begin
      st_nxt.fall = 1'b1;
    end
    if (st_nxt.fall && st_nxt.dn >= cpts_pkg::LEVEL_DN_CLEAR) begin
      st_nxt.fall = 1'b0;
      st_nxt.dn   = 3'd0;
      st_nxt.hi   = 1'b0;
    end
  end

endmodule

FILE: rtl/core/cpts_timebase.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpts_timebase
// Next count and pulse level of the free-running time base.
// ----------------------------------------------------------------------------
module cpts_timebase (
  input  logic [15:0] count,
  input  logic        level,
  input  logic [15:0] period,
  input  logic [15:0] pulse_width,
  output logic [15:0] count_nxt,
  output logic        level_nxt
);

  logic [16:0] cnt1;
  logic [17:0] cnt_sum;

  always_comb begin
    cnt1      = {1'b0, count} + 17'd1;
    cnt_sum   = {1'b0, cnt1} + {2'b00, pulse_width};
    level_nxt = level;
    count_nxt = cnt1[15:0];
    if (cnt_sum >= {2'b00, period} && cnt1 <= {1'b0, period}) begin
      level_nxt = 1'b1;
    end
    // period end, also when a smaller period was written
    if (cnt1 >= {1'b0, period}) begin
      level_nxt = 1'b0;
      count_nxt = 16'd0;
    end
  end

endmodule

FILE: rtl/core/conveyor_photo_trigger_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conveyor_photo_trigger_sequencer
// Tick-driven belt, camera trigger and strobe sequencer for a sorting conveyor.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-------------------------------------
//  in_     | in  | in_tvalid/in_tready  | in_tdata: one 1 ms tick of sensors
//  out_    | out | out_tvalid/out_tready| out_tdata: drives and flags
//  cfg_    | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data: register write
//
//  One item per clock while out_tready holds high: each accepted tick updates all
//  state in the same cycle and lands in the output register, so one item leaves
//  per cycle. out_tvalid rises in the cycle after an in_ accept.
//  in_tready is high whenever the output register is empty or being drained.
//  Reset (rst_n low, synchronous) restores the register defaults and the
//  idle state: belts off, trigger high, strobe off. cfg_ready is always high.
// ----------------------------------------------------------------------------
module conveyor_photo_trigger_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [0] cycle_enable, [1] barrier_in, [2] level_in, [7:3] zero
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  // out_tdata: [0] flat_belt_on, [1] v_belt_on, [2] trigger_n, [3] strobe_on,
  //            [4] base_pulse, [5] barrier_rise, [6] barrier_fall, [7] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Configuration
  logic [15:0] base_period_r;
  logic [15:0] pulse_width_r;
  logic [7:0]  trigger_low_r;
  logic [7:0]  strobe_ticks_r;

  // Sequencer state
  logic [15:0]        base_count_r, base_count_nxt;
  logic               base_level_r, base_level_nxt;
  cpts_pkg::qual_st_t barrier_r, barrier_nxt;
  cpts_pkg::qual_st_t level_r, level_nxt;
  cpts_pkg::qual_st_t belt_r, belt_nxt;
  logic [7:0]         photo_count_r, photo_count_nxt;
  logic               flat_r, flat_nxt;
  logic               vbelt_r, vbelt_nxt;
  logic               trig_n_r, trig_n_nxt;
  logic               strobe_r, strobe_nxt;

  // Output register
  logic       out_valid_r;
  logic [7:0] out_data_r;

  logic               in_acc;
  logic               cyc, bar, lvl;
  logic               flat_mid;
  logic [8:0]         photo_inc;
  cpts_pkg::qual_st_t barrier_q, level_q, belt_q;

  assign cfg_ready  = 1'b1;
  assign in_tready  = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign cyc = in_tdata[0];
  assign bar = in_tdata[1];
  assign lvl = in_tdata[2];

  cpts_timebase u_timebase (
    .count       (base_count_r),
    .level       (base_level_r),
    .period      (base_period_r),
    .pulse_width (pulse_width_r),
    .count_nxt   (base_count_nxt),
    .level_nxt   (base_level_nxt)
  );

  cpts_qual u_barrier_qual (
    .x      (bar),
    .st     (barrier_r),
    .st_nxt (barrier_q)
  );

  cpts_level_qual u_level_qual (
    .x      (lvl),
    .st     (level_r),
    .st_nxt (level_q)
  );

  // belt qualifier watches the flat drive after this tick's start/stop
  cpts_qual u_belt_qual (
    .x      (flat_mid),
    .st     (belt_r),
    .st_nxt (belt_q)
  );

  always_comb begin
    // flat belt: time base pulse starts it, a pending level rise stops it
    flat_mid = flat_r;
    if (base_level_nxt) begin
      flat_mid = 1'b1;
    end
    if (level_r.rise) begin
      flat_mid = 1'b0;
    end

    barrier_nxt     = barrier_r;
    level_nxt       = level_r;
    belt_nxt        = belt_r;
    photo_count_nxt = photo_count_r;
    flat_nxt        = flat_r;
    vbelt_nxt       = vbelt_r;
    trig_n_nxt      = trig_n_r;
    strobe_nxt      = strobe_r;
    photo_inc       = {1'b0, photo_count_r};

    if (!cyc) begin
      // cycle off: flat belt and flags cleared, level qualifier re-armed
      flat_nxt       = 1'b0;
      barrier_nxt.rise = 1'b0;
      barrier_nxt.fall = 1'b0;
      belt_nxt.rise  = 1'b0;
      belt_nxt.fall  = 1'b0;
      level_nxt.up   = 3'd0;
      level_nxt.dn   = 3'd0;
      level_nxt.hi   = 1'b1;
      level_nxt.rise = 1'b0;
      level_nxt.fall = 1'b0;
    end else begin
      barrier_nxt = barrier_q;
      level_nxt   = level_q;
      belt_nxt    = belt_q;
      flat_nxt    = flat_mid;

      if (belt_q.rise) begin
        vbelt_nxt = 1'b1;
      end
      if (barrier_q.rise) begin
        vbelt_nxt = 1'b0;
      end

      // photo sequence, started by a qualified level fall
      if (level_q.fall || photo_count_r != 8'd0) begin
        photo_inc = {1'b0, photo_count_r} + 9'd1;
      end
      if (photo_inc != 9'd0 && photo_inc <= {1'b0, trigger_low_r}) begin
        trig_n_nxt = 1'b0;
      end
      if (photo_inc != 9'd0 && photo_inc <= cpts_pkg::STROBE_FORCE_END) begin
        strobe_nxt = 1'b1;
      end
      if (photo_inc >= cpts_pkg::TRIGGER_RELEASE) begin
        trig_n_nxt = 1'b1;
      end
      photo_count_nxt = photo_inc[7:0];
      if (photo_inc >= {1'b0, strobe_ticks_r}) begin
        strobe_nxt      = 1'b0;
        photo_count_nxt = 8'd0;
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_period_r  <= cpts_pkg::RST_BASE_PERIOD;
      pulse_width_r  <= cpts_pkg::RST_PULSE_WIDTH;
      trigger_low_r  <= cpts_pkg::RST_TRIGGER_LOW;
      strobe_ticks_r <= cpts_pkg::RST_STROBE_TICKS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cpts_pkg::REG_BASE_PERIOD:  base_period_r  <= cfg_data;
        cpts_pkg::REG_PULSE_WIDTH:  pulse_width_r  <= cfg_data;
        cpts_pkg::REG_TRIGGER_LOW:  trigger_low_r  <= cfg_data[7:0];
        cpts_pkg::REG_STROBE_TICKS: strobe_ticks_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // state advances once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_count_r  <= 16'd0;
      base_level_r  <= 1'b0;
      barrier_r     <= '0;
      level_r       <= '{up: 3'd0, dn: 3'd0, hi: 1'b1, rise: 1'b0, fall: 1'b0};
      belt_r        <= '0;
      photo_count_r <= 8'd0;
      flat_r        <= 1'b0;
      vbelt_r       <= 1'b0;
      trig_n_r      <= 1'b1;
      strobe_r      <= 1'b0;
    end else if (in_acc) begin
      base_count_r  <= base_count_nxt;
      base_level_r  <= base_level_nxt;
      barrier_r     <= barrier_nxt;
      level_r       <= level_nxt;
      belt_r        <= belt_nxt;
      photo_count_r <= photo_count_nxt;
      flat_r        <= flat_nxt;
      vbelt_r       <= vbelt_nxt;
      trig_n_r      <= trig_n_nxt;
      strobe_r      <= strobe_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= {1'b0, barrier_nxt.fall, barrier_nxt.rise, base_level_nxt,
                     strobe_nxt, trig_n_nxt, vbelt_nxt, flat_nxt};
    end
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the conveyor photo trigger sequencer: sensor ticks
// go in with random gaps, a tick-level predictor builds the expected belt,
// trigger, strobe and flag word, and every result item is checked in order.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WATCHDOG_LIMIT  = 1000;  // quiet cycles before giving up
  localparam int HOLD_OFF_CYCLES = 64;    // long receiver stall
  localparam int TAIL_CYCLES     = 10;    // idle tail after the last result
  localparam int MAX_REPORTS     = 10;

  // in_tdata fields, highest bit first
  typedef struct packed {
    logic level_in;
    logic barrier_in;
    logic cycle_enable;
  } sensor_tick_t;

  // out_tdata fields, highest bit first (spare is the zero pad bit)
  typedef struct packed {
    logic spare;
    logic barrier_fall;
    logic barrier_rise;
    logic base_pulse;
    logic strobe_on;
    logic trigger_n;
    logic v_belt_on;
    logic flat_belt_on;
  } drive_word_t;

  string field_name [8] = '{"flat_belt_on", "v_belt_on", "trigger_n", "strobe_on",
                            "base_pulse", "barrier_rise", "barrier_fall", "spare"};

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [15:0] cfg_data;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  conveyor_photo_trigger_sequencer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Predictor state: register copies and sequencer state after reset
  // --------------------------------------------------------------------------
  logic [15:0] cur_period      = cpts_pkg::RST_BASE_PERIOD;
  logic [15:0] cur_pulse_width = cpts_pkg::RST_PULSE_WIDTH;
  logic [7:0]  cur_trigger_low = cpts_pkg::RST_TRIGGER_LOW;
  logic [7:0]  cur_strobe      = cpts_pkg::RST_STROBE_TICKS;

  logic [16:0]        base_count = '0;
  logic               base_level = 1'b0;
  cpts_pkg::qual_st_t barrier_q  = '0;   // starts in the last-was-low state
  cpts_pkg::qual_st_t belt_q     = '0;
  logic [2:0]         level_up   = '0;
  logic [2:0]         level_dn   = '0;
  logic               level_hi   = 1'b1; // level sensor starts as last-was-high
  logic               level_rise = 1'b0;
  logic               level_fall = 1'b0;
  logic [8:0]         photo_count = '0;
  logic               flat_on = 1'b0;
  logic               v_on    = 1'b0;
  logic               trig_n  = 1'b1;
  logic               strobe  = 1'b0;

  drive_word_t pending_drives [$];  // expected result items, oldest first
  int          fail_count = 0;
  int          result_idx = 0;
  int          quiet_cycles = 0;
  logic        no_gaps = 1'b0;      // free-flow stretch on both sides
  logic        hold_output = 1'b0;  // asks the receiver for a long stall

  // held sensor levels for the random stream
  logic        cyc_held = 1'b1;
  logic        bar_held = 1'b0;
  logic        lvl_held = 1'b1;

  // One rise/fall qualifier: 3 ticks raise a flag, 6 clear it and flip hi.
  function automatic cpts_pkg::qual_st_t qualify(cpts_pkg::qual_st_t q, logic x);
    if (x && !q.hi) q.up = q.up + 3'd1;
    if (x && q.up >= cpts_pkg::QUAL_SET) q.rise = 1'b1;
    if (q.rise && q.up >= cpts_pkg::QUAL_CLEAR) begin
      q.rise = 1'b0;
      q.up   = '0;
      q.hi   = 1'b1;
    end
    if (!x && q.hi) q.dn = q.dn + 3'd1;
    if (!x && q.dn >= cpts_pkg::QUAL_SET) q.fall = 1'b1;
    if (q.fall && q.dn >= cpts_pkg::QUAL_CLEAR) begin
      q.fall = 1'b0;
      q.dn   = '0;
      q.hi   = 1'b0;
    end
    return q;
  endfunction

  // Advance the sequencer by one tick and return the drive word it shows.
  function automatic drive_word_t advance_tick(sensor_tick_t t);
    drive_word_t r;
    // time base runs whether the cycle is on or not
    base_count = base_count + 17'd1;
    if (int'(base_count) + int'(cur_pulse_width) >= int'(cur_period) &&
        base_count <= cur_period)
      base_level = 1'b1;
    if (base_count >= cur_period) begin
      base_level = 1'b0;
      base_count = '0;
    end

    if (!t.cycle_enable) begin
      // cycle off: flat belt and all qualifier flags drop, level qualifier re-arms
      flat_on       = 1'b0;
      barrier_q.rise = 1'b0;
      barrier_q.fall = 1'b0;
      belt_q.rise   = 1'b0;
      belt_q.fall   = 1'b0;
      level_rise    = 1'b0;
      level_fall    = 1'b0;
      level_up      = '0;
      level_dn      = '0;
      level_hi      = 1'b1;
    end else begin
      barrier_q = qualify(barrier_q, t.barrier_in);

      // flat belt: started by the pulse, stopped by last tick's level rise
      if (base_level) flat_on = 1'b1;
      if (level_rise) flat_on = 1'b0;

      // level rise counter keeps running once started, wraps to idle
      if ((t.level_in && !level_hi) || level_up > 3'd0) level_up = level_up + 3'd1;
      if (t.level_in && level_up >= cpts_pkg::LEVEL_UP_SET &&
          level_up < cpts_pkg::LEVEL_UP_CLEAR)
        level_rise = 1'b1;
      if (level_rise && level_up >= cpts_pkg::LEVEL_UP_CLEAR) begin
        level_rise = 1'b0;
        level_up   = '0;
        level_hi   = 1'b1;
      end
      if (!t.level_in && level_hi) level_dn = level_dn + 3'd1;
      if (!t.level_in && level_dn >= cpts_pkg::LEVEL_DN_SET &&
          level_dn < cpts_pkg::LEVEL_DN_CLEAR)
        level_fall = 1'b1;
      if (level_fall && level_dn >= cpts_pkg::LEVEL_DN_CLEAR) begin
        level_fall = 1'b0;
        level_dn   = '0;
        level_hi   = 1'b0;
      end

      belt_q = qualify(belt_q, flat_on);
      if (belt_q.rise)    v_on = 1'b1;
      if (barrier_q.rise) v_on = 1'b0;

      // photo sequence: trigger low, strobe on, trigger release, strobe end
      if (level_fall || photo_count >= 9'd1) photo_count = photo_count + 9'd1;
      if (photo_count >= 9'd1 && photo_count <= cur_trigger_low) trig_n = 1'b0;
      if (photo_count >= 9'd1 && photo_count <= cpts_pkg::STROBE_FORCE_END)
        strobe = 1'b1;
      if (photo_count >= cpts_pkg::TRIGGER_RELEASE) trig_n = 1'b1;
      if (photo_count >= cur_strobe) begin
        strobe      = 1'b0;
        photo_count = '0;
      end
    end

    r.spare        = 1'b0;
    r.flat_belt_on = flat_on;
    r.v_belt_on    = v_on;
    r.trigger_n    = trig_n;
    r.strobe_on    = strobe;
    r.base_pulse   = base_level;
    r.barrier_rise = barrier_q.rise;
    r.barrier_fall = barrier_q.fall;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers (called at a falling edge, return at a falling edge)
  // --------------------------------------------------------------------------
  task automatic push_tick(sensor_tick_t t);
    if (!no_gaps && $urandom_range(0, 99) < 6) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, t};
    do @(posedge clk); while (!in_tready);
    pending_drives.push_back(advance_tick(t));
    @(negedge clk);
  endtask

  task automatic run_ticks(logic cyc, logic bar, logic lvl, int n);
    repeat (n) push_tick('{level_in: lvl, barrier_in: bar, cycle_enable: cyc});
  endtask

  // Mostly held sensor levels that flip now and then, so the qualifiers
  // get through; noise_pct of the ticks are raw random glitches.
  task automatic wander_ticks(int n, int noise_pct);
    sensor_tick_t t;
    repeat (n) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        t = sensor_tick_t'(3'($urandom_range(0, 7)));
      end else begin
        if ($urandom_range(0, 6) == 0) bar_held = !bar_held;
        if ($urandom_range(0, 8) == 0) lvl_held = !lvl_held;
        if (cyc_held) begin
          if ($urandom_range(0, 59) == 0) cyc_held = 1'b0;
        end else if ($urandom_range(0, 2) == 0) begin
          cyc_held = 1'b1;
        end
        t = '{level_in: lvl_held, barrier_in: bar_held, cycle_enable: cyc_held};
      end
      push_tick(t);
    end
  endtask

  // Stop offering and wait until every expected item has come back.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      cpts_pkg::REG_BASE_PERIOD:  cur_period      = val;
      cpts_pkg::REG_PULSE_WIDTH:  cur_pulse_width = val;
      cpts_pkg::REG_TRIGGER_LOW:  cur_trigger_low = val[7:0];
      cpts_pkg::REG_STROBE_TICKS: cur_strobe      = val[7:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Registers change only with the block idle.
  task automatic load_settings(logic [15:0] period, logic [15:0] width,
                               logic [7:0] trig_low, logic [7:0] strobe_end);
    settle();
    write_reg(cpts_pkg::REG_BASE_PERIOD, period);
    write_reg(cpts_pkg::REG_PULSE_WIDTH, width);
    write_reg(cpts_pkg::REG_TRIGGER_LOW, {8'd0, trig_low});
    write_reg(cpts_pkg::REG_STROBE_TICKS, {8'd0, strobe_end});
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Register defaults: cycle off, then a couple of ticks with level high.
  task automatic check_reset_defaults();
    run_ticks(1'b0, 1'b0, 1'b0, 1);
    run_ticks(1'b1, 1'b0, 1'b1, 2);
  endtask

  // Small settings; strobe end below the trigger release point, so the
  // trigger stays low after the sequence. Walks both qualifiers through
  // rise and fall, a level fall that starts a photo, a level rise, and a
  // cycle-off tick in the middle of it all.
  task automatic check_directed_sequences();
    load_settings(16'd4, 16'd1, 8'd1, 8'd2);
    run_ticks(1'b1, 1'b1, 1'b0, 6);  // barrier rise, level fall, photo
    run_ticks(1'b1, 1'b0, 1'b1, 6);  // barrier fall, level rise
    run_ticks(1'b1, 1'b1, 1'b1, 3);  // barrier rise again
    run_ticks(1'b0, 1'b1, 1'b1, 1);  // cycle off clears flags
    run_ticks(1'b1, 1'b0, 1'b0, 5);
  endtask

  // Several register settings, extremes among them.
  task automatic check_config_phases();
    logic [15:0] period;
    logic [15:0] width;
    // largest everything: pulse high on almost every tick
    load_settings(16'd65535, 16'd65534, 8'd255, 8'd255);
    wander_ticks(110, 15);
    // count now far above the new period, which ends it at once
    load_settings(16'd20, 16'd5, 8'd30, 8'd100);
    wander_ticks(110, 15);
    load_settings(16'd2, 16'd1, 8'd1, 8'd2);
    wander_ticks(100, 15);
    // pulse width beyond the period, strobe end before trigger release
    load_settings(16'd10, 16'd65534, 8'd255, 8'd60);
    wander_ticks(100, 15);
    load_settings(cpts_pkg::RST_BASE_PERIOD, cpts_pkg::RST_PULSE_WIDTH,
                  cpts_pkg::RST_TRIGGER_LOW, cpts_pkg::RST_STROBE_TICKS);
    wander_ticks(80, 15);
    repeat (3) begin
      period = 16'($urandom_range(2, 60));
      width  = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65534))
                                           : 16'($urandom_range(1, period));
      load_settings(period, width, 8'($urandom_range(1, 255)), 8'($urandom_range(2, 255)));
      wander_ticks(100, 15);
    end
  endtask

  // Neither side idles for a whole phase.
  task automatic check_free_flow();
    load_settings(16'd12, 16'd3, 8'd40, 8'd80);
    no_gaps = 1'b1;
    wander_ticks(90, 10);
    no_gaps = 1'b0;
  endtask

  // Receiver stalls for a long stretch while ticks keep coming, so the
  // output register fills and in_tready drops.
  task automatic check_output_backpressure();
    hold_output = 1'b1;
    wander_ticks(30, 10);
  endtask

  // Sender stops until every result is back, then carries on.
  task automatic check_sender_pause();
    wander_ticks(10, 10);
    settle();
    wander_ticks(10, 10);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    check_reset_defaults();
    check_directed_sequences();
    check_config_phases();
    check_free_flow();
    check_output_backpressure();
    check_sender_pause();

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_drives.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("conveyor_photo_trigger_sequencer test passed");
    end else begin
      $display("conveyor_photo_trigger_sequencer test failed");
    end
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_output) begin
        hold_output = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      out_tready <= no_gaps || ($urandom_range(0, 99) >= 6);
    end
  end

  // Result check: each accepted item against the oldest expectation.
  always @(posedge clk) begin : drive_checker
    drive_word_t want;
    string       wrong;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_drives.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("result %0d: unexpected item %b", result_idx, out_tdata);
      end else begin
        want  = pending_drives.pop_front();
        wrong = "";
        for (int i = 0; i < 8; i++)
          if (out_tdata[i] !== want[i]) wrong = {wrong, " ", field_name[i]};
        if (wrong != "") begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("result %0d: expected %b got %b, wrong:%s",
                     result_idx, want, out_tdata, wrong);
        end
      end
      result_idx++;
    end
  end

  // Watchdog: too many cycles with no handshake anywhere.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("conveyor_photo_trigger_sequencer test failed");
        $finish;
      end
    end
  end

endmodule
